/* rtl/core/swm_pkg.sv */
`default_nettype none

package swm_pkg;

    // window depth and sample format
    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 32;

    // derived widths
    localparam int IDX_W    = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
    localparam int RESULT_W = SAMPLE_WIDTH + 1;
    localparam int CFG_W    = 7;

    localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(3);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [RESULT_W-1:0]     result_t;
    typedef logic [CNT_W-1:0]               count_t;
    typedef logic [IDX_W-1:0]               index_t;

    // broadcast to every sorted cell for one update
    typedef struct packed {
        sample_t sample;
        sample_t oldest;
        logic    remove;
    } cell_ctl_t;

    // what a cell shows its left neighbor: stored value and its compare
    typedef struct packed {
        sample_t val;
        logic    le;
    } cell_peer_t;

    // what a cell hands its right neighbor: value after the removal step
    typedef struct packed {
        sample_t val;
        logic    le;
    } cell_chain_t;

    // clamp a written window length into 1..MAX_WINDOW
    function automatic count_t clamp_window(input logic [CFG_W-1:0] raw);
        count_t k;
        begin
            if (raw == '0)
            begin
                k = CNT_W'(1);
            end
            else if ({{(32-CFG_W){1'b0}}, raw} > 32'(MAX_WINDOW))
            begin
                k = CNT_W'(MAX_WINDOW);
            end
            else
            begin
                k = CNT_W'(raw);
            end
            return k;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/swm_in_if.sv */
`default_nettype none

interface swm_in_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::sample_t     sample;
    logic                 restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

/* rtl/core/swm_out_if.sv */
`default_nettype none

interface swm_out_if;
    logic                 valid;
    logic                 ready;
    swm_pkg::result_t     median_twice;

    modport source (output valid, output median_twice, input ready);
    modport sink   (input valid, input median_twice, output ready);
endinterface

`default_nettype wire

/* rtl/core/swm_cell.sv */
`default_nettype none

module swm_cell (
    input  wire logic                  clk,
    input  wire logic                  load,
    input  wire swm_pkg::cell_ctl_t    ctl,
    input  wire logic                  in_range,
    input  wire swm_pkg::cell_peer_t   right,
    input  wire swm_pkg::cell_chain_t  left,
    output swm_pkg::cell_peer_t        peer,
    output swm_pkg::cell_chain_t       chain
);

    swm_pkg::sample_t val_reg;
    swm_pkg::sample_t val_next;
    logic             le_own;
    logic             lt_old;
    logic             take_right;

    // local compares against the new sample and the leaving sample
    assign le_own     = (val_reg <= ctl.sample);
    assign lt_old     = (val_reg < ctl.oldest);
    assign take_right = ctl.remove && !lt_old;

    assign peer.val = val_reg;
    assign peer.le  = le_own;

    // contents after the leaving sample is taken out
    always_comb
    begin
        chain.val = take_right ? right.val : val_reg;
        chain.le  = in_range && (take_right ? right.le : le_own);
    end

    // insertion: keep, take the new sample, or take the left neighbor
    always_comb
    begin
        if (chain.le)
        begin
            val_next = chain.val;
        end
        else if (left.le)
        begin
            val_next = ctl.sample;
        end
        else
        begin
            val_next = left.val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            val_reg <= val_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/swm_arrival.sv */
`default_nettype none

module swm_arrival (
    input  wire logic              clk,
    input  wire logic              load,
    input  wire logic              full,
    input  wire swm_pkg::index_t   wr_pos,
    input  wire swm_pkg::sample_t  sample,
    output swm_pkg::sample_t       oldest
);

    swm_pkg::sample_t line_reg  [swm_pkg::MAX_WINDOW];
    swm_pkg::sample_t line_next [swm_pkg::MAX_WINDOW];

    // when full the line shifts toward the head; new sample lands at wr_pos
    always_comb
    begin
        for (int i = 0; i < swm_pkg::MAX_WINDOW; i++)
        begin
            if (swm_pkg::IDX_W'(i) == wr_pos)
            begin
                line_next[i] = sample;
            end
            else if (full && (i + 1 < swm_pkg::MAX_WINDOW))
            begin
                line_next[i] = line_reg[(i + 1) % swm_pkg::MAX_WINDOW];
            end
            else
            begin
                line_next[i] = line_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < swm_pkg::MAX_WINDOW; i++)
            begin
                line_reg[i] <= line_next[i];
            end
        end
    end

    assign oldest = line_reg[0];

endmodule

`default_nettype wire

/* rtl/core/sliding_window_median.sv */
`default_nettype none

// Sliding-window median filter. Takes one signed sample per transaction and
// keeps the last window_size samples (1 to 64, reset 3) both in arrival order
// and in a row of sorted cells. Once the window is full every sample produces
// one result, twice the median: the sum of the two middle sorted samples, so an
// even window gives an exact mean with no rounding. restart or a write to
// window_size empties the window. The block takes one sample every clock
// unless an output stall holds it; each sample removes the oldest entry and
// inserts the new one across the whole cell row, all cells updating together.
// Its result is then summed from the cells into the output register; an
// output stall leaves at most one further result pending in the cells.
module sliding_window_median (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [swm_pkg::CFG_W-1:0]  cfg_wdata,
    swm_in_if.sink                          in_ch,
    swm_out_if.source                       out_ch
);

    localparam int N = swm_pkg::MAX_WINDOW;

    swm_pkg::count_t    k_reg;
    swm_pkg::count_t    fill_reg;
    swm_pkg::count_t    fill_next;
    logic               pend_reg;
    logic               out_valid_reg;
    swm_pkg::result_t   out_data_reg;

    swm_pkg::count_t    fill_eff;
    swm_pkg::count_t    live_count;
    swm_pkg::index_t    wr_pos;
    swm_pkg::index_t    lo_idx;
    swm_pkg::index_t    hi_idx;
    logic               full;
    logic               emit;
    logic               accept;
    logic               drain;
    swm_pkg::sample_t   oldest;
    swm_pkg::cell_ctl_t ctl;

    swm_pkg::cell_peer_t  peer  [N];
    swm_pkg::cell_chain_t chain [N];
    swm_pkg::cell_peer_t  right_in [N];
    swm_pkg::cell_chain_t left_in  [N];
    logic [N-1:0]         in_range;

    // handshake
    assign drain        = pend_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !pend_reg || drain;
    assign accept       = in_ch.valid && in_ch.ready;

    // window bookkeeping for the incoming sample
    always_comb
    begin
        fill_eff = (in_ch.restart || (fill_reg > k_reg)) ? '0 : fill_reg;
        full     = (fill_eff == k_reg);
        if (full)
        begin
            live_count = k_reg - swm_pkg::CNT_W'(1);
            fill_next  = fill_eff;
            emit       = 1'b1;
        end
        else
        begin
            live_count = fill_eff;
            fill_next  = fill_eff + swm_pkg::CNT_W'(1);
            emit       = (fill_next == k_reg);
        end
        wr_pos = live_count[swm_pkg::IDX_W-1:0];
    end

    // arrival order line
    swm_arrival u_arrival (
        .clk    (clk),
        .load   (accept),
        .full   (full),
        .wr_pos (wr_pos),
        .sample (in_ch.sample),
        .oldest (oldest)
    );

    assign ctl.sample = in_ch.sample;
    assign ctl.oldest = oldest;
    assign ctl.remove = full;

    // row of sorted cells with neighbor links
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        assign in_range[i] = (swm_pkg::CNT_W'(i) < live_count);

        if (i == N - 1)
        begin : g_last
            assign right_in[i].val = peer[i].val;
            assign right_in[i].le  = 1'b0;
        end
        else
        begin : g_mid
            assign right_in[i] = peer[i + 1];
        end

        if (i == 0)
        begin : g_first
            assign left_in[i].val = in_ch.sample;
            assign left_in[i].le  = 1'b1;
        end
        else
        begin : g_rest
            assign left_in[i] = chain[i - 1];
        end

        swm_cell u_cell (
            .clk      (clk),
            .load     (accept),
            .ctl      (ctl),
            .in_range (in_range[i]),
            .right    (right_in[i]),
            .left     (left_in[i]),
            .peer     (peer[i]),
            .chain    (chain[i])
        );
    end

    // middle taps of the window
    always_comb
    begin
        swm_pkg::count_t km1;
        km1    = k_reg - swm_pkg::CNT_W'(1);
        lo_idx = km1[swm_pkg::CNT_W-1:1];
        hi_idx = k_reg[swm_pkg::CNT_W-1:1];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= swm_pkg::WINDOW_RESET;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                k_reg    <= swm_pkg::clamp_window(cfg_wdata);
                fill_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end

            if (accept)
            begin
                pend_reg <= emit;
            end
            else if (drain)
            begin
                pend_reg <= 1'b0;
            end

            if (drain)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result register, summed from the settled cells
    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_data_reg <= swm_pkg::result_t'(peer[lo_idx].val)
                          + swm_pkg::result_t'(peer[hi_idx].val);
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.median_twice = out_data_reg;

endmodule

`default_nettype wire

/* verif/tb_sliding_window_median.sv */
`default_nettype none

module tb_sliding_window_median;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 6;
    localparam int DIR_ROWS     = 21;
    localparam int PHASES       = 12;

    // one row of the directed table
    typedef struct packed {
        swm_pkg::sample_t smp;
        logic             rs;
        logic             typed;
        swm_pkg::result_t want;
    } dir_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [swm_pkg::CFG_W-1:0] cfg_wdata;

    swm_in_if  in_bus ();
    swm_out_if out_bus ();

    sliding_window_median uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_bus),
        .out_ch    (out_bus)
    );

    // predictor state: window in arrival order and in sorted order
    swm_pkg::sample_t          line_pred [swm_pkg::MAX_WINDOW];
    swm_pkg::sample_t          sort_pred [swm_pkg::MAX_WINDOW];
    int                        fill_pred;
    logic [swm_pkg::CFG_W-1:0] win_pred;

    swm_pkg::result_t median_q [$];
    int               err_count;
    int               sent_count;
    int               median_count;
    int               quiet_cycles;
    int               stall_left;
    bit               idle_on;

    dir_row_t dir_rows [DIR_ROWS];
    int       phase_win   [PHASES];
    int       phase_items [PHASES];

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // print one mismatch line and count it
    task automatic report_mismatch(input string what, input swm_pkg::result_t got,
                                   input swm_pkg::result_t want);
        begin
            $display("[%0t] mismatch: %s got=%h want=%h", $realtime, what, got, want);
            err_count++;
        end
    endtask

    // insert v into the first n sorted entries
    function automatic void sorted_put(input int n, input swm_pkg::sample_t v);
        int i;
        begin
            i = n;
            while (i > 0 && sort_pred[i-1] > v)
            begin
                sort_pred[i] = sort_pred[i-1];
                i--;
            end
            sort_pred[i] = v;
        end
    endfunction

    // advance the predicted window by one sample; returns 1 when a median is due
    function automatic bit step_window(input swm_pkg::sample_t s, input logic rs,
                                       output swm_pkg::result_t r);
        int               k;
        int               i;
        int               pos;
        swm_pkg::sample_t oldest;
        begin
            r = '0;
            k = int'(win_pred);
            if (k == 0)
            begin
                k = 1;
            end
            if (k > swm_pkg::MAX_WINDOW)
            begin
                k = swm_pkg::MAX_WINDOW;
            end
            if (rs)
            begin
                fill_pred = 0;
            end
            if (fill_pred > k)
            begin
                fill_pred = 0;
            end
            if (fill_pred < k)
            begin
                line_pred[fill_pred] = s;
                sorted_put(fill_pred, s);
                fill_pred++;
                if (fill_pred < k)
                begin
                    return 1'b0;
                end
            end
            else
            begin
                oldest = line_pred[0];
                for (i = 0; i + 1 < k; i++)
                begin
                    line_pred[i] = line_pred[i+1];
                end
                line_pred[k-1] = s;
                // drop the first sorted entry equal to the oldest sample
                pos = k;
                for (i = 0; i < k; i++)
                begin
                    if (sort_pred[i] == oldest)
                    begin
                        pos = i;
                        break;
                    end
                end
                for (i = pos; i + 1 < k; i++)
                begin
                    sort_pred[i] = sort_pred[i+1];
                end
                sorted_put(k - 1, s);
            end
            r = {sort_pred[(k-1)/2][swm_pkg::SAMPLE_WIDTH-1], sort_pred[(k-1)/2]}
              + {sort_pred[k/2][swm_pkg::SAMPLE_WIDTH-1], sort_pred[k/2]};
            return 1'b1;
        end
    endfunction

    // random sample: full range, a narrow band for duplicates, or near the extremes
    function automatic swm_pkg::sample_t pick_sample();
        int mode;
        begin
            mode = $urandom_range(0, 9);
            case (mode) inside
                [0:3]:   return swm_pkg::sample_t'($urandom);
                [4:6]:   return swm_pkg::sample_t'(int'($urandom_range(0, 8)) - 4);
                7:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
                8:       return swm_pkg::sample_t'(32'h7FFFFFFF - $urandom_range(0, 3));
                default: return swm_pkg::sample_t'(32'h80000000 + $urandom_range(0, 3));
            endcase
        end
    endfunction

    // offer one sample transaction and predict its result once accepted
    task automatic send_sample(input swm_pkg::sample_t s, input logic rs, input bit typed,
                               input swm_pkg::result_t typed_want);
        swm_pkg::result_t r;
        bit               got;
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                in_bus.valid = 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge clk);
            end
            in_bus.sample  = s;
            in_bus.restart = rs;
            in_bus.valid   = 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!in_bus.ready);
            got = step_window(s, rs, r);
            if (typed)
            begin
                median_q = {median_q, typed_want};
            end
            else if (got)
            begin
                median_q = {median_q, r};
            end
            sent_count++;
        end
    endtask

    // stop offering and let every outstanding result drain
    task automatic drain_block();
        begin
            @(negedge clk);
            in_bus.valid = 1'b0;
            while (median_q.size() != 0)
            begin
                @(posedge clk);
            end
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    // write window_size while the block is idle
    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] v);
        begin
            drain_block();
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_wdata = v;
            @(negedge clk);
            cfg_we    = 1'b0;
            win_pred  = v;
            fill_pred = 0;
        end
    endtask

    // output side: random stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_bus.ready = 1'b0;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            out_bus.ready = 1'b0;
            stall_left = $urandom_range(1, 5) - 1;
        end
        else
        begin
            out_bus.ready = 1'b1;
        end
    end

    // result checking against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            if (median_q.size() == 0)
            begin
                report_mismatch("result with nothing expected", out_bus.median_twice, '0);
            end
            else
            begin
                if (out_bus.median_twice !== median_q[0])
                begin
                    report_mismatch("median_twice", out_bus.median_twice, median_q[0]);
                end
                void'(median_q.pop_front());
                median_count++;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int      p;
        int      n;
        int      k;
        logic    rs;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_bus.valid   = 1'b0;
        in_bus.sample  = '0;
        in_bus.restart = 1'b0;
        out_bus.ready  = 1'b0;
        err_count      = 0;
        sent_count     = 0;
        median_count   = 0;
        quiet_cycles   = 0;
        stall_left     = 0;
        idle_on        = 1'b1;
        fill_pred      = 0;
        win_pred       = swm_pkg::CFG_W'(swm_pkg::WINDOW_RESET);
        for (n = 0; n < swm_pkg::MAX_WINDOW; n++)
        begin
            line_pred[n] = '0;
            sort_pred[n] = '0;
        end

        // window of three after reset: extremes, restart, duplicates
        dir_rows = '{
            '{32'sd5,          1'b0, 1'b0, 33'sd0},
            '{-32'sd7,         1'b0, 1'b0, 33'sd0},
            '{32'sd100,        1'b0, 1'b1, 33'sd10},
            '{32'sh7FFFFFFF,   1'b0, 1'b0, 33'sd0},
            '{32'sh7FFFFFFF,   1'b0, 1'b1, 33'sh0FFFFFFFE},
            '{32'sh80000000,   1'b0, 1'b1, 33'sh0FFFFFFFE},
            '{32'sh80000000,   1'b0, 1'b1, 33'sh100000000},
            '{32'sh80000000,   1'b0, 1'b1, 33'sh100000000},
            '{32'sd0,          1'b1, 1'b0, 33'sd0},
            '{-32'sd1,         1'b0, 1'b0, 33'sd0},
            '{32'sd1,          1'b0, 1'b0, 33'sd0},
            '{32'sd1,          1'b0, 1'b0, 33'sd0},
            '{32'sd1,          1'b1, 1'b0, 33'sd0},
            '{32'sd1,          1'b1, 1'b0, 33'sd0},
            '{32'sd2,          1'b0, 1'b0, 33'sd0},
            '{32'sd2,          1'b0, 1'b0, 33'sd0},
            '{32'sd2,          1'b0, 1'b0, 33'sd0},
            '{-32'sd2,         1'b0, 1'b0, 33'sd0},
            '{32'sh55555555,   1'b0, 1'b0, 33'sd0},
            '{32'shAAAAAAAA,   1'b0, 1'b0, 33'sd0},
            '{32'sh0000FFFF,   1'b0, 1'b0, 33'sd0}
        };

        // window settings: zero and oversize values clamp, last one back to reset value
        phase_win   = '{1, 0, 2, 64, 127, 65, 4, 5, 8, 17, 33, 3};
        phase_items = '{90, 90, 90, 180, 180, 180, 90, 90, 90, 90, 90, 90};

        // reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (n = 0; n < DIR_ROWS; n++)
        begin
            send_sample(dir_rows[n].smp, dir_rows[n].rs, dir_rows[n].typed, dir_rows[n].want);
        end

        // random phases, one per window setting
        for (p = 0; p < PHASES; p++)
        begin
            write_window(swm_pkg::CFG_W'(phase_win[p]));
            if (p >= PHASES - 2)
            begin
                idle_on = 1'b0;
            end
            k = phase_win[p];
            if (k == 0)
            begin
                k = 1;
            end
            if (k > swm_pkg::MAX_WINDOW)
            begin
                k = swm_pkg::MAX_WINDOW;
            end
            for (n = 0; n < phase_items[p]; n++)
            begin
                rs = ($urandom_range(0, 3 * k + 8) == 0);
                send_sample(pick_sample(), rs, 1'b0, '0);
            end
        end

        // wait out the tail
        drain_block();
        if (median_q.size() != 0)
        begin
            report_mismatch("expected results never arrived", '0,
                            swm_pkg::result_t'(median_q.size()));
        end

        $display("%0d samples sent across %0d window settings including clamped sizes",
                 sent_count, PHASES + 1);
        $display("%0d medians checked, %0d mismatches", median_count, err_count);
        if (err_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
